// ----- hw/rtl/spq_pkg.sv -----
// Shared codes, widths and types for the sorted min-priority queue.
package spq_pkg;

    // Action codes carried on the request channel
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_PEEK    = 2'd2;

    // Status codes returned with every response
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Fixed widths of the response fields
    localparam int HEAD_W = 32;
    localparam int OCC_W  = 5;

    // Widest value and count handled before a field is cut to size
    localparam int WIDE_W = 64;

    // Command broadcast to every cell of the chain
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD   = 2'd0;
    localparam cell_op_t CELL_INSERT = 2'd1;
    localparam cell_op_t CELL_SHIFT  = 2'd2;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One storage cell of the sorted chain: compare, keep, take new value or shift.
module spq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  logic [DATA_WIDTH-1:0]   new_value,
    input  logic [DATA_WIDTH-1:0]   prev_data,
    input  logic                    prev_below,
    input  logic [DATA_WIDTH-1:0]   next_data,
    output logic [DATA_WIDTH-1:0]   data,
    output logic                    below
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Held entry is strictly smaller than the incoming value
    assign below = ctrl.occupied && ($signed(data_reg) < $signed(new_value));
    assign data  = data_reg;

    // Insert: keep if smaller, take the value at the boundary, else take from the left
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            spq_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            spq_pkg::CELL_INSERT:
            begin
                if (below)
                begin
                    data_next = data_reg;
                end
                else if (prev_below)
                begin
                    data_next = new_value;
                end
                else
                begin
                    data_next = prev_data;
                end
            end
            spq_pkg::CELL_SHIFT:
            begin
                data_next = next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- hw/rtl/sorted_min_priority_queue_top.sv -----
// Top level of the sorted min-priority queue: cell chain, count and response register.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-------------------------------
//  request  | req_valid | req_stall | action, value
//  response | rsp_valid | rsp_stall | head_value, status, occupancy
//
// Every request transaction gives one response transaction, valid in the next cycle.
// A new request is taken each cycle while req_stall is low; all cells compare against the
// incoming value in parallel and update in the same cycle, so the chain sets the rate.
// rst_n clears the count and response valid; cell contents are undefined.
// req_stall is high only while a response is held and rsp_stall is high.
module sorted_min_priority_queue_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    action,
    input  logic [DATA_WIDTH-1:0]         value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [spq_pkg::HEAD_W-1:0]    head_value,
    output logic [1:0]                    status,
    output logic [spq_pkg::OCC_W-1:0]     occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                         accept;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         full;
    logic                         empty;
    logic                         do_enq;
    logic                         do_deq;
    spq_pkg::cell_op_t            op;
    logic [DATA_WIDTH-1:0]        cell_data  [CAPACITY];
    logic                         cell_below [CAPACITY];
    logic [spq_pkg::WIDE_W-1:0]   head_wide;
    logic [spq_pkg::WIDE_W-1:0]   occ_wide;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic [spq_pkg::HEAD_W-1:0]   head_reg;
    logic [spq_pkg::HEAD_W-1:0]   head_next;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic [spq_pkg::OCC_W-1:0]    occ_reg;
    logic [spq_pkg::OCC_W-1:0]    occ_next;

    // Handshake: take a request whenever the response slot is free or draining
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Decode the operation against the current fill level
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_enq = accept && (action == spq_pkg::ACT_ENQUEUE) && !full;
    assign do_deq = accept && (action == spq_pkg::ACT_DEQUEUE) && !empty;

    always_comb
    begin
        if (do_enq)
        begin
            op = spq_pkg::CELL_INSERT;
        end
        else if (do_deq)
        begin
            op = spq_pkg::CELL_SHIFT;
        end
        else
        begin
            op = spq_pkg::CELL_HOLD;
        end
    end

    // Chain of cells, slot 0 holds the smallest entry
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::cell_ctrl_t   ctrl;
        logic [DATA_WIDTH-1:0] left_data;
        logic                  left_below;
        logic [DATA_WIDTH-1:0] right_data;

        assign ctrl.op       = op;
        assign ctrl.occupied = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_data  = value;
            assign left_below = 1'b1;
        end
        else
        begin : g_inner
            assign left_data  = cell_data[i-1];
            assign left_below = cell_below[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid
            assign right_data = cell_data[i+1];
        end

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_value  (value),
            .prev_data  (left_data),
            .prev_below (left_below),
            .next_data  (right_data),
            .data       (cell_data[i]),
            .below      (cell_below[i])
        );
    end

    // Fill count update
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Response fields, head and count cut to their port widths
    assign head_wide = spq_pkg::WIDE_W'(cell_data[0]);
    assign occ_wide  = spq_pkg::WIDE_W'(count_next);

    always_comb
    begin
        head_next   = '0;
        status_next = spq_pkg::STAT_OK;
        case (action)
            spq_pkg::ACT_ENQUEUE:
            begin
                if (full)
                begin
                    status_next = spq_pkg::STAT_FULL;
                end
            end
            spq_pkg::ACT_DEQUEUE, spq_pkg::ACT_PEEK:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::STAT_EMPTY;
                end
                else
                begin
                    head_next = head_wide[spq_pkg::HEAD_W-1:0];
                end
            end
            default:
            begin
                status_next = spq_pkg::STAT_OK;
            end
        endcase
        occ_next = occ_wide[spq_pkg::OCC_W-1:0];
    end

    // Response valid: set on accept, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg   <= head_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign head_value = head_reg;
    assign status     = status_reg;
    assign occupancy  = occ_reg;

endmodule

// ----- test/sorted_min_priority_queue_top_test.sv -----
// Self-checking testbench for the sorted min-priority queue: directed table, then random traffic.
module sorted_min_priority_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CALM_FROM    = 1300;   // no idling from here to the end
    localparam int DRAIN_AT     = 600;    // sender waits for all responses here

    // Action code the queue treats as a no-op
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [spq_pkg::HEAD_W-1:0] head;
        logic [1:0]                 status;
        logic [spq_pkg::OCC_W-1:0]  occ;
    } queue_result_t;

    // One row of the directed table; expected fields count only when fixed is set
    typedef struct packed {
        logic [1:0]                 act;
        logic [DATA_WIDTH-1:0]      val;
        logic                       fixed;
        logic [spq_pkg::HEAD_W-1:0] exp_head;
        logic [1:0]                 exp_status;
        logic [spq_pkg::OCC_W-1:0]  exp_occ;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{spq_pkg::ACT_PEEK,    32'h0000_0000, 1'b1, 32'h0000_0000, spq_pkg::STAT_EMPTY, 5'd0},
        '{spq_pkg::ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, spq_pkg::STAT_EMPTY, 5'd0},
        '{ACT_UNUSED,           32'h1234_5678, 1'b1, 32'h0000_0000, spq_pkg::STAT_OK,    5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, spq_pkg::STAT_OK,    5'd1},
        '{spq_pkg::ACT_ENQUEUE, 32'h8000_0000, 1'b1, 32'h0000_0000, spq_pkg::STAT_OK,    5'd2},
        '{spq_pkg::ACT_PEEK,    32'h0000_0000, 1'b1, 32'h8000_0000, spq_pkg::STAT_OK,    5'd2},
        '{spq_pkg::ACT_ENQUEUE, 32'h0000_0000, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h0000_0001, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h0000_0000, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h7FFF_FFFF, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h8000_0000, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h0000_0100, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'hFFFF_FF00, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h5555_5555, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'hAAAA_AAAA, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h7FFF_FFFE, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h8000_0001, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h0000_0001, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_ENQUEUE, 32'h1234_5678, 1'b1, 32'h0000_0000, spq_pkg::STAT_FULL, 5'd16},
        '{ACT_UNUSED,           32'hEDCB_A987, 1'b1, 32'h0000_0000, spq_pkg::STAT_OK,   5'd16},
        '{spq_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0},
        '{spq_pkg::ACT_PEEK,    32'h0000_0000, 1'b0, 32'h0, spq_pkg::STAT_OK, 5'd0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic [1:0]                 action;
    logic [DATA_WIDTH-1:0]      value;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic [spq_pkg::HEAD_W-1:0] head_value;
    logic [1:0]                 status;
    logic [spq_pkg::OCC_W-1:0]  occupancy;

    // Predicted queue contents, ascending, and responses still to arrive
    logic signed [DATA_WIDTH-1:0] held_entries[$];
    queue_result_t                pending_results[$];
    int                           mismatch_count = 0;
    bit                           idling_on = 1'b1;
    int                           stall_left = 0;

    sorted_min_priority_queue_top #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .value      (value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .head_value (head_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Apply one operation to the predicted queue and return its response
    function automatic queue_result_t predict_queue_op(input logic [1:0] act,
                                                      input logic signed [DATA_WIDTH-1:0] val);
        queue_result_t res;
        int pos;
        res = '{head: '0, status: spq_pkg::STAT_OK, occ: '0};
        case (act)
            spq_pkg::ACT_ENQUEUE:
            begin
                if (held_entries.size() >= CAPACITY)
                    res.status = spq_pkg::STAT_FULL;
                else
                begin
                    // newest of equal values goes ahead of the older ones
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos] < val)
                        pos++;
                    held_entries.insert(pos, val);
                end
            end
            spq_pkg::ACT_DEQUEUE, spq_pkg::ACT_PEEK:
            begin
                if (held_entries.size() == 0)
                    res.status = spq_pkg::STAT_EMPTY;
                else
                begin
                    res.head = held_entries[0];
                    if (act == spq_pkg::ACT_DEQUEUE)
                        void'(held_entries.pop_front());
                end
            end
            default: ;
        endcase
        res.occ = spq_pkg::OCC_W'(held_entries.size());
        return res;
    endfunction

    // Offer one request transaction and hold it until accepted
    task automatic send_item(input logic [1:0] act, input logic [DATA_WIDTH-1:0] val,
                             input logic fixed, input queue_result_t fixed_res);
        queue_result_t res;
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        value     <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        res = predict_queue_op(act, val);
        pending_results.push_back(fixed ? fixed_res : res);
    endtask

    task automatic wait_all_responses();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [1:0] pick_action(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACT_UNUSED;
        case (mode)
            0: return (r < 75) ? spq_pkg::ACT_ENQUEUE :
                      (r < 90) ? spq_pkg::ACT_DEQUEUE : spq_pkg::ACT_PEEK;  // fill
            1: return (r < 25) ? spq_pkg::ACT_ENQUEUE :
                      (r < 85) ? spq_pkg::ACT_DEQUEUE : spq_pkg::ACT_PEEK;  // drain
            2: return (r < 45) ? spq_pkg::ACT_ENQUEUE :
                      (r < 80) ? spq_pkg::ACT_DEQUEUE : spq_pkg::ACT_PEEK;  // mixed
            default: return (r < 50) ? spq_pkg::ACT_ENQUEUE :
                            (r < 70) ? spq_pkg::ACT_DEQUEUE : spq_pkg::ACT_PEEK;
        endcase
    endfunction

    // Random values half the time, with extremes and a narrow band to force ties
    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 4)
            return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    // Response side: check accepted transactions, stall in random bursts
    initial
    begin
        queue_result_t want;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("response with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    if (head_value !== want.head)
                        report_mismatch($sformatf("head_value %h, expected %h",
                                                  head_value, want.head));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (occupancy !== want.occ)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  occupancy, want.occ));
                end
            end
            if (stall_left != 0)
                stall_left--;
            else if (idling_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 12);
            rsp_stall <= (stall_left != 0);
        end
    end

    // Request side: reset, directed table, random traffic, verdict
    initial
    begin
        queue_result_t fixed_res;
        int mode;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        action    <= spq_pkg::ACT_ENQUEUE;
        value     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            fixed_res = '{head: DIRECTED[i].exp_head, status: DIRECTED[i].exp_status,
                          occ: DIRECTED[i].exp_occ};
            send_item(DIRECTED[i].act, DIRECTED[i].val, DIRECTED[i].fixed, fixed_res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = (n / 50) % 4;
            idling_on = (n < CALM_FROM) && ((n / 50) % 3 != 2);
            if (n == DRAIN_AT)
            begin
                req_valid <= 1'b0;
                wait_all_responses();
            end
            send_item(pick_action(mode), pick_value(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        wait_all_responses();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_min_priority_queue_top.sv
test/sorted_min_priority_queue_top_test.sv
